// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== hw/rtl/lba_pkg.sv =====
`timescale 1ns / 1ps
package lba_pkg;

    localparam int IDX_W      = 10;
    localparam int SER_W      = 10;
    localparam int LINK_W     = 11;
    localparam int CNT_W      = 6;
    localparam int TBL_ADDR_W = 16;

    localparam logic [LINK_W-1:0] NO_LINK = 11'h7FF;

    typedef struct packed {
        logic [IDX_W-1:0] base_block;
        logic [CNT_W-1:0] block_count;
    } alloc_in_t;

    typedef struct packed {
        logic             accepted;
        logic [IDX_W-1:0] block_index;
        logic [SER_W-1:0] serial_number;
        logic             fell_short;
        logic             last;
    } alloc_out_t;

    // Sequencer to table: one read, one allocation mark, one link write per cycle
    typedef struct packed {
        logic                  rd_en;
        logic [TBL_ADDR_W-1:0] rd_addr;
        logic                  mark_en;
        logic [TBL_ADDR_W-1:0] mark_addr;
        logic [SER_W-1:0]      mark_serial;
        logic                  link_en;
        logic [TBL_ADDR_W-1:0] link_addr;
        logic [LINK_W-1:0]     link_val;
    } tbl_cmd_t;

endpackage

// ===== hw/rtl/lba_table.sv =====
`timescale 1ns / 1ps
module lba_table #(
    parameter int TABLE_BLOCKS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  lba_pkg::tbl_cmd_t cmd,
    output logic             init_done,
    output logic             rd_used
);

    localparam int AW = (TABLE_BLOCKS > 1) ? $clog2(TABLE_BLOCKS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_BLOCKS - 1);

    logic                       used_mem   [TABLE_BLOCKS];
    logic [lba_pkg::SER_W-1:0]  serial_mem [TABLE_BLOCKS];
    logic [lba_pkg::LINK_W-1:0] link_mem   [TABLE_BLOCKS];

    logic          init_busy_reg, init_busy_next;
    logic [AW-1:0] init_addr_reg, init_addr_next;
    logic          rd_used_reg;

    logic          used_we;
    logic [AW-1:0] used_wa;
    logic          used_wd;
    logic          link_we;
    logic [AW-1:0] link_wa;
    logic [lba_pkg::LINK_W-1:0] link_wd;

    // Sweep the table once after reset: even blocks used, odd free, no links
    always_comb
    begin
        init_busy_next = init_busy_reg;
        init_addr_next = init_addr_reg;
        if (init_busy_reg)
        begin
            if (init_addr_reg == LAST_ADDR)
                init_busy_next = 1'b0;
            else
                init_addr_next = init_addr_reg + 1'b1;
        end
    end

    always_comb
    begin
        used_we = init_busy_reg || cmd.mark_en;
        used_wa = init_busy_reg ? init_addr_reg : cmd.mark_addr[AW-1:0];
        used_wd = init_busy_reg ? ~init_addr_reg[0] : 1'b1;
        link_we = init_busy_reg || cmd.link_en;
        link_wa = init_busy_reg ? init_addr_reg : cmd.link_addr[AW-1:0];
        link_wd = init_busy_reg ? lba_pkg::NO_LINK : cmd.link_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_addr_reg <= '0;
        end
        else
        begin
            init_busy_reg <= init_busy_next;
            init_addr_reg <= init_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
            used_mem[used_wa] <= used_wd;
        if (cmd.rd_en)
            rd_used_reg <= used_mem[cmd.rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_en)
            serial_mem[cmd.mark_addr[AW-1:0]] <= cmd.mark_serial;
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_wa] <= link_wd;
    end

    assign init_done = !init_busy_reg;
    assign rd_used   = rd_used_reg;

endmodule

// ===== hw/rtl/linked_block_allocator.sv =====
// Operation: a request walks the table from its start block to the last block it needs,
//   one table entry per cycle while the output register is not stalled, then flushes.
// Throughput: one request at a time; the next is taken only after its last response word
//   is loaded, since the single used-mark read port and the scan counter walk the table.
// Reset: rst_n is asynchronous, active low. After release an initialising pass over the table
//   rewrites the used marks and links; req_ready stays low until it finishes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module linked_block_allocator #(
    parameter int TABLE_BLOCKS = 1024,
    parameter int MAX_REQUEST  = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lba_pkg::alloc_in_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lba_pkg::alloc_out_t rsp
);

    localparam int AW = (TABLE_BLOCKS > 1) ? $clog2(TABLE_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_REQUEST + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_BLOCKS - 1);

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Scan pipeline: scan_addr is the next read, chk_addr the entry whose mark is back
    logic [AW-1:0] scan_addr_reg, scan_addr_next;
    logic [AW-1:0] chk_addr_reg, chk_addr_next;
    logic          chk_vld_reg, chk_vld_next;
    logic          issue_more_reg, issue_more_next;
    logic          first_reg, first_next;
    logic          range_bad_reg, range_bad_next;
    logic [CW-1:0] want_reg, want_next;
    logic [CW-1:0] found_reg, found_next;
    logic [CW-1:0] found_inc;

    // Global serial and the one block held back until we know whether it ends the chain
    logic [lba_pkg::SER_W-1:0] serial_reg, serial_next;
    logic                      pend_vld_reg, pend_vld_next;
    logic [AW-1:0]             pend_idx_reg, pend_idx_next;
    logic [lba_pkg::SER_W-1:0] pend_ser_reg, pend_ser_next;
    logic                      short_reg, short_next;

    // Output register parts the scan from the consumer
    lba_pkg::alloc_out_t out_reg, out_word;
    logic                out_vld_reg, out_vld_next;
    logic                out_load;
    logic                out_free;
    logic                emit_need;
    logic                stall;

    lba_pkg::tbl_cmd_t cmd;
    logic              init_done;
    logic              rd_used;

    lba_table #(
        .TABLE_BLOCKS (TABLE_BLOCKS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .init_done (init_done),
        .rd_used   (rd_used)
    );

    always_comb
    begin
        state_next      = state_reg;
        scan_addr_next  = scan_addr_reg;
        chk_addr_next   = chk_addr_reg;
        chk_vld_next    = chk_vld_reg;
        issue_more_next = issue_more_reg;
        first_next      = first_reg;
        range_bad_next  = range_bad_reg;
        want_next       = want_reg;
        found_next      = found_reg;
        serial_next     = serial_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        pend_ser_next   = pend_ser_reg;
        short_next      = short_reg;
        cmd             = '0;
        out_load        = 1'b0;
        out_word        = '0;
        out_free        = !out_vld_reg || rsp_ready;
        found_inc       = found_reg + 1'b1;
        // A returned mark needs the output register on a reject, on a zero-count
        // request, or when a new hit pushes the held block out
        emit_need       = first_reg ? (rd_used || (want_reg == '0))
                                    : (!rd_used && pend_vld_reg);
        stall           = chk_vld_reg && emit_need && !out_free;

        case (state_reg)
            ST_INIT:
            begin
                if (init_done)
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    scan_addr_next  = AW'(req.base_block);
                    range_bad_next  = 32'(req.base_block) >= 32'(TABLE_BLOCKS);
                    if (32'(req.block_count) > 32'(MAX_REQUEST))
                        want_next = CW'(MAX_REQUEST);
                    else
                        want_next = CW'(req.block_count);
                    found_next      = '0;
                    first_next      = 1'b1;
                    chk_vld_next    = 1'b0;
                    issue_more_next = 1'b1;
                    pend_vld_next   = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (range_bad_reg)
                begin
                    // Start block lies past the table: reject outright
                    if (out_free)
                    begin
                        out_load      = 1'b1;
                        out_word.last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (!stall)
                begin
                    // Advance the read one entry
                    if (issue_more_reg)
                    begin
                        cmd.rd_en     = 1'b1;
                        cmd.rd_addr   = lba_pkg::TBL_ADDR_W'(scan_addr_reg);
                        chk_addr_next = scan_addr_reg;
                        if (scan_addr_reg == LAST_ADDR)
                            issue_more_next = 1'b0;
                        else
                            scan_addr_next = scan_addr_reg + 1'b1;
                    end
                    chk_vld_next = issue_more_reg;

                    if (chk_vld_reg)
                    begin
                        first_next = 1'b0;
                        if (first_reg && (rd_used || (want_reg == '0)))
                        begin
                            // Used start block rejects; free start with zero count
                            // answers once and touches nothing
                            out_load          = 1'b1;
                            out_word.accepted = !rd_used;
                            out_word.last     = 1'b1;
                            state_next        = ST_IDLE;
                        end
                        else if (!rd_used)
                        begin
                            cmd.mark_en     = 1'b1;
                            cmd.mark_addr   = lba_pkg::TBL_ADDR_W'(chk_addr_reg);
                            cmd.mark_serial = serial_reg;
                            serial_next     = serial_reg + 1'b1;
                            if (pend_vld_reg)
                            begin
                                // Link the held block to this one and release it
                                cmd.link_en            = 1'b1;
                                cmd.link_addr          = lba_pkg::TBL_ADDR_W'(pend_idx_reg);
                                cmd.link_val           = lba_pkg::LINK_W'(chk_addr_reg);
                                out_load               = 1'b1;
                                out_word.accepted      = 1'b1;
                                out_word.block_index   = lba_pkg::IDX_W'(pend_idx_reg);
                                out_word.serial_number = pend_ser_reg;
                            end
                            pend_vld_next = 1'b1;
                            pend_idx_next = chk_addr_reg;
                            pend_ser_next = serial_reg;
                            found_next    = found_inc;
                            if (found_inc == want_reg)
                            begin
                                short_next = 1'b0;
                                state_next = ST_FLUSH;
                            end
                            else if (chk_addr_reg == LAST_ADDR)
                            begin
                                short_next = 1'b1;
                                state_next = ST_FLUSH;
                            end
                        end
                        else if (chk_addr_reg == LAST_ADDR)
                        begin
                            short_next = 1'b1;
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end

            ST_FLUSH:
            begin
                // Drop the held block out as the final beat of the chain
                if (out_free)
                begin
                    out_load               = 1'b1;
                    out_word.accepted      = 1'b1;
                    out_word.block_index   = lba_pkg::IDX_W'(pend_idx_reg);
                    out_word.serial_number = pend_ser_reg;
                    out_word.fell_short    = short_reg;
                    out_word.last          = 1'b1;
                    pend_vld_next          = 1'b0;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        if (out_load)
            out_vld_next = 1'b1;
        else if (rsp_ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            chk_vld_reg    <= 1'b0;
            issue_more_reg <= 1'b0;
            first_reg      <= 1'b0;
            range_bad_reg  <= 1'b0;
            serial_reg     <= '0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chk_vld_reg    <= chk_vld_next;
            issue_more_reg <= issue_more_next;
            first_reg      <= first_next;
            range_bad_reg  <= range_bad_next;
            serial_reg     <= serial_next;
            pend_vld_reg   <= pend_vld_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        chk_addr_reg  <= chk_addr_next;
        want_reg      <= want_next;
        found_reg     <= found_next;
        pend_idx_reg  <= pend_idx_next;
        pend_ser_reg  <= pend_ser_next;
        short_reg     <= short_next;
        if (out_load)
            out_reg <= out_word;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    `ASSERT_IMPLIES(a_idle_no_pend, req_ready, !pend_vld_reg)
    `ASSERT_NEXT(a_serial_step, cmd.mark_en, serial_reg == $past(serial_reg) + 10'd1)
    `ASSERT_IMPLIES(a_short_on_last, rsp_valid && rsp.fell_short, rsp.last)
    `ASSERT_IMPLIES(a_reject_alone, rsp_valid && !rsp.accepted, rsp.last && rsp.block_index == '0)
    `ASSERT_IMPLIES(a_link_with_mark, cmd.link_en, cmd.mark_en && pend_vld_reg)

endmodule
